// File: design/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types, register indexes and helpers for the 1-Wire bus master.
// ----------------------------------------------------------------------------
package owm_pkg;

  localparam int unsigned NumRegs   = 8;
  localparam int unsigned RegIdxW   = 3;
  localparam int unsigned TimeW     = 10;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned BitCntW   = 4;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned ApbAddrW  = 5;

  localparam logic [BitCntW-1:0] ByteBits = 4'd8;
  localparam logic [TimeW-1:0]   ResetRecoveryUs = 10'd410;

  // register indexes
  localparam logic [RegIdxW-1:0] RegWriteOneLow   = 3'd0;
  localparam logic [RegIdxW-1:0] RegWriteOneRest  = 3'd1;
  localparam logic [RegIdxW-1:0] RegWriteZeroLow  = 3'd2;
  localparam logic [RegIdxW-1:0] RegWriteZeroRest = 3'd3;
  localparam logic [RegIdxW-1:0] RegReadSampleWait = 3'd4;
  localparam logic [RegIdxW-1:0] RegReadRest      = 3'd5;
  localparam logic [RegIdxW-1:0] RegResetLow      = 3'd6;
  localparam logic [RegIdxW-1:0] RegPresenceWait  = 3'd7;

  // function codes
  localparam logic [2:0] FuncTick  = 3'd0;
  localparam logic [2:0] FuncReset = 3'd1;
  localparam logic [2:0] FuncWBit  = 3'd2;
  localparam logic [2:0] FuncRBit  = 3'd3;
  localparam logic [2:0] FuncWByte = 3'd4;
  localparam logic [2:0] FuncRByte = 3'd5;

  typedef logic [NumRegs-1:0][TimeW-1:0] cfg_t;

  typedef struct packed {
    logic [2:0]       func;
    logic [ByteW-1:0] data_in;
    logic             line_level;
  } in_item_t;

  typedef struct packed {
    logic             drive_low;
    logic             busy_res;
    logic             done_res;
    logic [ByteW-1:0] read_value;
    logic             presence;
  } out_item_t;

  // a zero timing value still lasts one tick
  function automatic logic [TimeW-1:0] ticks_of(input logic [TimeW-1:0] v);
    ticks_of = (v == '0) ? {{(TimeW-1){1'b0}}, 1'b1} : v;
  endfunction

endpackage

// File: design/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master
// 1-Wire bus master at standard speed, one input transfer per microsecond tick.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i / in_ready_o in_item_i  (func, data_in, line_level)
//   out       output     out_valid_o/ out_ready_i out_item_o (drive_low .. presence)
//   cfg       input      APB, pready tied high   8 timing registers, 10 bits each
//
// Each tick's transfer can be accepted every cycle while the skid register is empty.
// The tick's result is registered; a skid register holds one more result
// while the output stalls, and in_ready_o drops only when that is full.
// Reset returns the sequencer to idle and the registers to their defaults.
// ----------------------------------------------------------------------------
module one_wire_bus_master (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  owm_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output owm_pkg::out_item_t            out_item_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [owm_pkg::ApbAddrW-1:0]  paddr,
  input  logic [owm_pkg::ApbDataW-1:0]  pwdata,
  output logic [owm_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import owm_pkg::*;

  cfg_t      cfg;
  out_item_t res;
  out_item_t out_q, skid_q;
  logic      out_valid_q, skid_valid_q;
  logic      in_fire;
  logic      out_free;

  owm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  owm_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_fire),
    .item_i (in_item_i),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = out_ready_i || !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= res;
      end
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result with output empty");

  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && in_fire) |=> skid_valid_q)
    else $error("transfer during stall not held in skid");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_ready_i) |=> (!skid_valid_q && out_valid_q))
    else $error("skid did not drain into output");

endmodule

// File: design/owm_regs.sv
// ----------------------------------------------------------------------------
// owm_regs
// APB register file holding the slot timing values.
// ----------------------------------------------------------------------------
module owm_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [owm_pkg::ApbAddrW-1:0]  paddr,
  input  logic [owm_pkg::ApbDataW-1:0]  pwdata,
  output logic [owm_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output owm_pkg::cfg_t                 cfg_o
);
  import owm_pkg::*;

  cfg_t              cfg_q;
  logic [RegIdxW-1:0] idx;
  logic               wr_en;

  assign idx    = paddr[ApbAddrW-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[RegWriteOneLow]    <= 10'd6;
      cfg_q[RegWriteOneRest]   <= 10'd64;
      cfg_q[RegWriteZeroLow]   <= 10'd60;
      cfg_q[RegWriteZeroRest]  <= 10'd10;
      cfg_q[RegReadSampleWait] <= 10'd9;
      cfg_q[RegReadRest]       <= 10'd55;
      cfg_q[RegResetLow]       <= 10'd480;
      cfg_q[RegPresenceWait]   <= 10'd70;
    end else if (wr_en) begin
      cfg_q[idx] <= pwdata[TimeW-1:0];
    end
  end

  assign prdata = {{(ApbDataW-TimeW){1'b0}}, cfg_q[idx]};
  assign cfg_o  = cfg_q;

endmodule

// File: design/owm_engine.sv
// ----------------------------------------------------------------------------
// owm_engine
// Slot sequencer: advances the bus phase by one tick per step and forms the
// result of that tick.
// ----------------------------------------------------------------------------
module owm_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  owm_pkg::in_item_t   item_i,
  input  owm_pkg::cfg_t       cfg_i,
  output owm_pkg::out_item_t  res_o
);
  import owm_pkg::*;

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhLow  = 2'd1;
  localparam logic [1:0] PhWait = 2'd2;
  localparam logic [1:0] PhRest = 2'd3;

  logic [1:0]         phase_q, phase_d;
  logic [TimeW-1:0]   cnt_q, cnt_d;
  logic [2:0]         op_q, op_d;
  logic [BitCntW-1:0] bits_q, bits_d;
  logic [ByteW-1:0]   sh_q, sh_d;
  logic               cur_bit_q, cur_bit_d;
  logic               sample_q, sample_d;
  logic [ByteW-1:0]   rval_q, rval_d;
  logic               pres_q, pres_d;
  logic               drive, busy, done;
  logic               start;

  assign start = (phase_q == PhIdle) && (item_i.func >= FuncReset) &&
                 (item_i.func <= FuncRByte);

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    op_d      = op_q;
    bits_d    = bits_q;
    sh_d      = sh_q;
    cur_bit_d = cur_bit_q;
    sample_d  = sample_q;
    rval_d    = rval_q;
    pres_d    = pres_q;
    drive     = 1'b0;
    busy      = 1'b0;
    done      = 1'b0;

    if (start) begin
      op_d     = item_i.func;
      sample_d = 1'b0;
      case (item_i.func)
        FuncWBit: begin
          sh_d   = {{(ByteW-1){1'b0}}, (item_i.data_in != '0)};
          bits_d = {{(BitCntW-1){1'b0}}, 1'b1};
        end
        FuncWByte: begin
          sh_d   = item_i.data_in;
          bits_d = ByteBits;
        end
        FuncRByte: begin
          sh_d   = '0;
          bits_d = ByteBits;
        end
        default: begin
          sh_d   = '0;
          bits_d = {{(BitCntW-1){1'b0}}, 1'b1};
        end
      endcase
      // first slot
      phase_d = PhLow;
      if (op_d == FuncReset) begin
        cnt_d = ticks_of(cfg_i[RegResetLow]);
      end else if (op_d == FuncRBit || op_d == FuncRByte) begin
        cnt_d = ticks_of(cfg_i[RegWriteOneLow]);
      end else begin
        cur_bit_d = sh_d[0];
        sh_d      = {1'b0, sh_d[ByteW-1:1]};
        cnt_d     = cur_bit_d ? ticks_of(cfg_i[RegWriteOneLow])
                              : ticks_of(cfg_i[RegWriteZeroLow]);
      end
    end

    if (phase_d != PhIdle) begin
      busy  = 1'b1;
      drive = (phase_d == PhLow);
      if (phase_d == PhRest && sample_d) begin
        sample_d = 1'b0;
        if (op_d == FuncReset) begin
          sh_d = {{(ByteW-1){1'b0}}, !item_i.line_level};
        end else if (op_d == FuncRBit) begin
          sh_d = {{(ByteW-1){1'b0}}, item_i.line_level};
        end else begin
          sh_d = {item_i.line_level, sh_d[ByteW-1:1]};
        end
      end
      cnt_d = cnt_d - 1'b1;
      if (cnt_d == '0) begin
        case (phase_d)
          PhLow: begin
            if (op_d == FuncWBit || op_d == FuncWByte) begin
              phase_d = PhRest;
              cnt_d   = cur_bit_d ? ticks_of(cfg_i[RegWriteOneRest])
                                  : ticks_of(cfg_i[RegWriteZeroRest]);
            end else begin
              phase_d = PhWait;
              cnt_d   = (op_d == FuncReset) ? ticks_of(cfg_i[RegPresenceWait])
                                            : ticks_of(cfg_i[RegReadSampleWait]);
            end
          end
          PhWait: begin
            phase_d  = PhRest;
            cnt_d    = (op_d == FuncReset) ? ticks_of(ResetRecoveryUs)
                                           : ticks_of(cfg_i[RegReadRest]);
            sample_d = 1'b1;
          end
          default: begin
            if (bits_d != '0) begin
              bits_d = bits_d - 1'b1;
            end
            if (bits_d != '0) begin
              // next slot of a byte
              phase_d = PhLow;
              if (op_d == FuncRBit || op_d == FuncRByte) begin
                cnt_d = ticks_of(cfg_i[RegWriteOneLow]);
              end else begin
                cur_bit_d = sh_d[0];
                sh_d      = {1'b0, sh_d[ByteW-1:1]};
                cnt_d     = cur_bit_d ? ticks_of(cfg_i[RegWriteOneLow])
                                      : ticks_of(cfg_i[RegWriteZeroLow]);
              end
            end else begin
              if (op_d == FuncReset) begin
                pres_d = sh_d[0];
              end else if (op_d == FuncRBit || op_d == FuncRByte) begin
                rval_d = sh_d;
              end
              done    = 1'b1;
              phase_d = PhIdle;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      cnt_q     <= '0;
      op_q      <= FuncTick;
      bits_q    <= '0;
      sh_q      <= '0;
      cur_bit_q <= 1'b0;
      sample_q  <= 1'b0;
      rval_q    <= '0;
      pres_q    <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      op_q      <= op_d;
      bits_q    <= bits_d;
      sh_q      <= sh_d;
      cur_bit_q <= cur_bit_d;
      sample_q  <= sample_d;
      rval_q    <= rval_d;
      pres_q    <= pres_d;
    end
  end

  assign res_o.drive_low  = drive;
  assign res_o.busy_res   = busy;
  assign res_o.done_res   = done;
  assign res_o.read_value = rval_d;
  assign res_o.presence   = pres_d;

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.done_res |-> res_o.busy_res)
    else $error("done without busy");

  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PhIdle) |-> (cnt_q != '0))
    else $error("active phase with zero count");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.done_res) |=> (phase_q == PhIdle))
    else $error("command finished but phase not idle");

endmodule

// File: sim/tb_one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// tb_one_wire_bus_master
// Self-checking bench for the 1-Wire bus master. A table of directed commands
// (idle ticks, spare codes, resets with and without presence, bit and byte
// slots, commands issued while busy) runs under default, minimum and zero
// slot timings. Random command sequences follow under several random
// timing sets. Every result transfer is compared against a cycle model of
// the sequencer; sender bursts and receiver stalls vary throughout.
// ----------------------------------------------------------------------------
module tb_one_wire_bus_master;
  import owm_pkg::*;

  localparam int NumDirRows = 17;
  localparam int CfgDefault = 0;
  localparam int CfgMin     = 1;
  localparam int CfgZero    = 2;

  // spare function codes, treated as plain ticks
  localparam logic [2:0] FuncRsvdA = 3'd6;
  localparam logic [2:0] FuncRsvdB = 3'd7;

  typedef enum logic [1:0] {PhIdle, PhLow, PhWait, PhRest} seq_phase_e;
  typedef enum logic [1:0] {LvLow, LvHigh, LvRand} lv_mode_e;

  typedef struct {
    logic [2:0] func;
    logic [7:0] data;
    lv_mode_e   lv;
    bit         noisy;
    int         cfg_set;
    bit         chk_read;
    logic [7:0] want_read;
    bit         chk_pres;
    bit         want_pres;
  } dir_row_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  in_item_t            in_item   = '0;
  logic                out_ready = 1'b0;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [ApbAddrW-1:0] paddr     = '0;
  logic [ApbDataW-1:0] pwdata    = '0;
  logic                in_ready;
  logic                out_valid;
  out_item_t           out_item;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // sequencer model state
  cfg_t        timing = {10'd70, 10'd480, 10'd55, 10'd9, 10'd10, 10'd60, 10'd64, 10'd6};
  seq_phase_e  seq_phase   = PhIdle;
  int unsigned seq_cnt     = 0;
  logic [2:0]  seq_op      = FuncTick;
  logic [3:0]  bits_left   = '0;
  logic [7:0]  seq_shift   = '0;
  logic        seq_bit     = 1'b0;
  logic        sample_pend = 1'b0;
  logic [7:0]  rd_val      = '0;
  logic        pres_seen   = 1'b0;

  out_item_t   result_q [$];
  int          errors     = 0;
  int          work_items = 0;
  int          burst_left = 0;
  logic [8:0]  rx_cyc     = '0;
  dir_row_t    dir_rows [NumDirRows];
  cfg_t        cfg_sets [3];

  one_wire_bus_master dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk = ~clk;

  function automatic void log_error(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("[%0t] ERROR %s", $time, msg);
    end
  endfunction

  function automatic void check_eq(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
    if (got !== want) begin
      log_error($sformatf("%s: expected %0h got %0h", what, want, got));
    end
  endfunction

  // zero-valued timing still lasts a tick
  function automatic int unsigned slot_len(input logic [TimeW-1:0] v);
    return (v == '0) ? 1 : int'(v);
  endfunction

  function automatic void begin_slot();
    seq_phase = PhLow;
    if (seq_op == FuncReset) begin
      seq_cnt = slot_len(timing[RegResetLow]);
    end else if (seq_op == FuncRBit || seq_op == FuncRByte) begin
      seq_cnt = slot_len(timing[RegWriteOneLow]);
    end else begin
      seq_bit   = seq_shift[0];
      seq_shift = seq_shift >> 1;
      seq_cnt   = seq_bit ? slot_len(timing[RegWriteOneLow])
                          : slot_len(timing[RegWriteZeroLow]);
    end
  endfunction

  // one microsecond tick of the sequencer
  function automatic out_item_t bus_tick(input in_item_t it);
    out_item_t r;
    r = '0;
    if (seq_phase == PhIdle && it.func >= FuncReset && it.func <= FuncRByte) begin
      seq_op      = it.func;
      sample_pend = 1'b0;
      case (it.func)
        FuncWBit: begin
          seq_shift = (it.data_in != '0) ? 8'h01 : 8'h00;
          bits_left = 4'd1;
        end
        FuncWByte: begin
          seq_shift = it.data_in;
          bits_left = ByteBits;
        end
        FuncRByte: begin
          seq_shift = '0;
          bits_left = ByteBits;
        end
        default: begin
          seq_shift = '0;
          bits_left = 4'd1;
        end
      endcase
      begin_slot();
    end
    if (seq_phase != PhIdle) begin
      r.busy_res  = 1'b1;
      r.drive_low = (seq_phase == PhLow);
      if (seq_phase == PhRest && sample_pend) begin
        sample_pend = 1'b0;
        if (seq_op == FuncReset) begin
          seq_shift = {7'd0, ~it.line_level};
        end else if (seq_op == FuncRBit) begin
          seq_shift = {7'd0, it.line_level};
        end else begin
          seq_shift = {it.line_level, seq_shift[7:1]};
        end
      end
      seq_cnt--;
      if (seq_cnt == 0) begin
        case (seq_phase)
          PhLow: begin
            if (seq_op == FuncWBit || seq_op == FuncWByte) begin
              seq_phase = PhRest;
              seq_cnt   = seq_bit ? slot_len(timing[RegWriteOneRest])
                                  : slot_len(timing[RegWriteZeroRest]);
            end else begin
              seq_phase = PhWait;
              seq_cnt   = (seq_op == FuncReset) ? slot_len(timing[RegPresenceWait])
                                                : slot_len(timing[RegReadSampleWait]);
            end
          end
          PhWait: begin
            seq_phase   = PhRest;
            seq_cnt     = (seq_op == FuncReset) ? slot_len(ResetRecoveryUs)
                                                : slot_len(timing[RegReadRest]);
            sample_pend = 1'b1;
          end
          default: begin
            if (bits_left > 0) bits_left--;
            if (bits_left > 0) begin
              begin_slot();
            end else begin
              if (seq_op == FuncReset) begin
                pres_seen = seq_shift[0];
              end else if (seq_op == FuncRBit || seq_op == FuncRByte) begin
                rd_val = seq_shift;
              end
              r.done_res = 1'b1;
              seq_phase  = PhIdle;
            end
          end
        endcase
      end
    end
    r.read_value = rd_val;
    r.presence   = pres_seen;
    return r;
  endfunction

  function automatic logic line_for(input lv_mode_e m);
    case (m)
      LvLow:   return 1'b0;
      LvHigh:  return 1'b1;
      default: return 1'($urandom_range(0, 1));
    endcase
  endfunction

  task automatic send_item(input logic [2:0] func, input logic [7:0] data, input logic lvl);
    in_item_t  it;
    out_item_t want;
    int        gap;
    it = '{func: func, data_in: data, line_level: lvl};
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    want = bus_tick(it);
    if (want.busy_res) work_items++;
    result_q.push_back(want);
  endtask

  // command tick, then ticks until the sequence ends; noisy adds commands while busy
  task automatic run_command(input logic [2:0] func, input logic [7:0] data,
                             input lv_mode_e mode, input bit noisy);
    logic [2:0] f;
    send_item(func, data, line_for(mode));
    while (seq_phase != PhIdle) begin
      f = (noisy && $urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : FuncTick;
      send_item(f, 8'($urandom), line_for(mode));
    end
  endtask

  // bring the block to rest: sequencer idle, every result transferred
  task automatic settle();
    while (seq_phase != PhIdle) send_item(FuncTick, 8'($urandom), 1'($urandom));
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input int idx, input logic [TimeW-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'(idx * 4);
    pwdata  <= ApbDataW'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input int idx, input logic [TimeW-1:0] want);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ApbAddrW'(idx * 4);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_eq($sformatf("register %0d readback", idx), 32'(want), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_timing(input cfg_t vals);
    settle();
    for (int i = 0; i < NumRegs; i++) begin
      apb_write(i, vals[i]);
      timing[i] = vals[i];
    end
    for (int i = 0; i < NumRegs; i++) check_reg(i, vals[i]);
  endtask

  // receiver: ready pattern chosen by the top two bits of rx_cyc
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1'b1;
    case (rx_cyc[8:7])
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= 1'($urandom_range(0, 1));
      2'd2:    out_ready <= (rx_cyc[2:0] > 3'd2);
      default: out_ready <= (rx_cyc[4:0] > 5'd20);
    endcase
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        log_error($sformatf("result transfer with nothing pending: %0h", out_item));
      end else begin
        want = result_q.pop_front();
        check_eq("drive_low", 32'(want.drive_low), 32'(out_item.drive_low));
        check_eq("busy_res", 32'(want.busy_res), 32'(out_item.busy_res));
        check_eq("done_res", 32'(want.done_res), 32'(out_item.done_res));
        check_eq("read_value", 32'(want.read_value), 32'(out_item.read_value));
        check_eq("presence", 32'(want.presence), 32'(out_item.presence));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb_one_wire_bus_master failed");
    $finish;
  end

  initial begin
    cfg_t     cfg;
    dir_row_t row;
    int       cfg_now;
    int       stop_at;
    int       lo;
    int       hi;

    cfg_sets[CfgDefault] = timing;
    cfg_sets[CfgMin]     = {NumRegs{10'd1}};
    cfg_sets[CfgZero]    = '0;
    cfg_now              = CfgDefault;

    // func, data, line, noisy, timing set, chk read, read, chk presence, presence
    dir_rows = '{
      '{FuncTick,  8'hFF, LvHigh, 1'b0, CfgDefault, 1'b1, 8'h00, 1'b1, 1'b0},
      '{FuncRsvdA, 8'h00, LvLow,  1'b0, CfgDefault, 1'b1, 8'h00, 1'b1, 1'b0},
      '{FuncRsvdB, 8'h81, LvHigh, 1'b0, CfgDefault, 1'b1, 8'h00, 1'b1, 1'b0},
      '{FuncRBit,  8'h00, LvHigh, 1'b0, CfgDefault, 1'b1, 8'h01, 1'b0, 1'b0},
      '{FuncReset, 8'h00, LvLow,  1'b0, CfgMin,     1'b0, 8'h00, 1'b1, 1'b1},
      '{FuncRByte, 8'h3C, LvLow,  1'b0, CfgMin,     1'b1, 8'h00, 1'b0, 1'b0},
      '{FuncWByte, 8'hFF, LvRand, 1'b1, CfgMin,     1'b0, 8'h00, 1'b0, 1'b0},
      '{FuncWByte, 8'h00, LvRand, 1'b1, CfgMin,     1'b0, 8'h00, 1'b0, 1'b0},
      '{FuncRByte, 8'h00, LvRand, 1'b1, CfgMin,     1'b0, 8'h00, 1'b0, 1'b0},
      '{FuncWBit,  8'h01, LvRand, 1'b0, CfgMin,     1'b0, 8'h00, 1'b0, 1'b0},
      '{FuncWBit,  8'h80, LvHigh, 1'b0, CfgMin,     1'b0, 8'h00, 1'b0, 1'b0},
      '{FuncWBit,  8'h00, LvHigh, 1'b0, CfgMin,     1'b0, 8'h00, 1'b0, 1'b0},
      '{FuncRBit,  8'hFF, LvHigh, 1'b0, CfgMin,     1'b1, 8'h01, 1'b0, 1'b0},
      '{FuncReset, 8'h00, LvHigh, 1'b1, CfgZero,    1'b0, 8'h00, 1'b1, 1'b0},
      '{FuncRBit,  8'h00, LvLow,  1'b0, CfgZero,    1'b1, 8'h00, 1'b0, 1'b0},
      '{FuncWByte, 8'h5A, LvRand, 1'b0, CfgZero,    1'b0, 8'h00, 1'b0, 1'b0},
      '{FuncRByte, 8'h00, LvHigh, 1'b0, CfgZero,    1'b1, 8'hFF, 1'b0, 1'b0}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < NumRegs; i++) check_reg(i, timing[i]);

    for (int r = 0; r < NumDirRows; r++) begin
      row = dir_rows[r];
      if (row.cfg_set != cfg_now) begin
        program_timing(cfg_sets[row.cfg_set]);
        cfg_now = row.cfg_set;
      end
      run_command(row.func, row.data, row.lv, row.noisy);
      if (row.chk_read) check_eq($sformatf("row %0d read_value", r), 32'(row.want_read),
                                 32'(rd_val));
      if (row.chk_pres) check_eq($sformatf("row %0d presence", r), 32'(row.want_pres),
                                 32'(pres_seen));
    end

    // random bit and byte commands on short slots; resets stay in the table,
    // since the fixed recovery time alone runs over 400 ticks
    for (int ph = 0; ph < 4; ph++) begin
      lo = (ph == 2) ? 0 : 1;
      hi = (ph == 3) ? 5 : 3;
      for (int i = 0; i < NumRegs; i++) cfg[i] = 10'($urandom_range(lo, hi));
      program_timing(cfg);
      stop_at = work_items + 25;
      while (work_items < stop_at) begin
        if ($urandom_range(0, 4) == 0) begin
          case ($urandom_range(0, 2))
            0:       send_item(FuncTick, 8'($urandom), 1'($urandom));
            1:       send_item(FuncRsvdA, 8'($urandom), 1'($urandom));
            default: send_item(FuncRsvdB, 8'($urandom), 1'($urandom));
          endcase
        end else begin
          run_command(3'($urandom_range(FuncWBit, FuncRByte)), 8'($urandom),
                      lv_mode_e'($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
        end
      end
    end

    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb_one_wire_bus_master passed");
    end else begin
      $display("tb_one_wire_bus_master failed");
    end
    $finish;
  end

endmodule
